### design/tgcc_pkg.sv
package tgcc_pkg;

    localparam int GRID_SIZE_DEF  = 32;
    localparam int COORD_BITS_DEF = 16;

    localparam int CELL_SHIFT = 4;
    localparam int CELL_MASK  = (1 << CELL_SHIFT) - 1;

    localparam int CELL_W     = 5;
    localparam int Y_OFFSET_W = 5;
    localparam int REACH_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [Y_OFFSET_W-1:0] Y_OFFSET_RESET = Y_OFFSET_W'(15);
    localparam logic [REACH_W-1:0]    REACH_RESET    = REACH_W'(25600);

    typedef enum logic [0:0] {
        OP_MAP_WRITE = 1'b0,
        OP_POINT     = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Y_OFFSET = 1'b0,
        CFG_REACH    = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STOP_NONE     = 2'd0,
        STOP_REACH    = 2'd1,
        STOP_OBSTACLE = 2'd2
    } stop_t;

    typedef struct packed {
        logic valid;
        logic is_point;
        logic first;
        logic last;
        logic map_wr;
    } item_ctl_t;

endpackage

### design/tgcc_if.sv
interface tgcc_in_if import tgcc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         first_point;
    logic                         last_point;
    logic [CELL_W-1:0]            cell_x;
    logic [CELL_W-1:0]            cell_y;
    logic                         cell_occupied;

    modport source (
        output valid, opcode, point_x, point_y, first_point, last_point,
               cell_x, cell_y, cell_occupied,
        input  ready
    );

    modport sink (
        input  valid, opcode, point_x, point_y, first_point, last_point,
               cell_x, cell_y, cell_occupied,
        output ready
    );
endinterface

interface tgcc_out_if;
    logic       valid;
    logic       ready;
    logic       path_clear;
    logic [1:0] stop_reason;

    modport source (
        output valid, path_clear, stop_reason,
        input  ready
    );

    modport sink (
        input  valid, path_clear, stop_reason,
        output ready
    );
endinterface

### design/tgcc_point_front.sv
module tgcc_point_front import tgcc_pkg::*; #(
    parameter int GRID_SIZE  = GRID_SIZE_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  logic [Y_OFFSET_W-1:0]                 y_offset,
    tgcc_in_if.sink                               item,
    output logic                                  rd_en,
    output logic [$clog2(GRID_SIZE)-1:0]          rd_row,
    output item_ctl_t                             s1_ctl,
    output logic [$clog2(GRID_SIZE)-1:0]          s1_row,
    output logic [$clog2(GRID_SIZE)-1:0]          s1_col,
    output logic                                  s1_bit,
    output logic signed [COORD_BITS:0]            s1_dx,
    output logic signed [COORD_BITS:0]            s1_dy
);

    localparam int IDX_W    = $clog2(GRID_SIZE);
    localparam int Q_W      = COORD_BITS + 1;
    localparam int GRID_MAX = GRID_SIZE - 1;

    function automatic logic [IDX_W-1:0] clamp_cell(input logic signed [Q_W:0] v);
        logic [IDX_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > GRID_MAX)
        begin
            r = IDX_W'(GRID_MAX);
        end
        else
        begin
            r = v[IDX_W-1:0];
        end
        return r;
    endfunction

    logic signed [COORD_BITS-1:0] origin_x_reg;
    logic signed [COORD_BITS-1:0] origin_y_reg;

    logic                  accept;
    logic                  is_point;
    logic                  take_origin;
    logic signed [Q_W-1:0] px;
    logic signed [Q_W-1:0] py;
    logic signed [Q_W-1:0] ox;
    logic signed [Q_W-1:0] oy;
    logic signed [Q_W-1:0] qx_sum;
    logic signed [Q_W-1:0] qy_sum;
    logic signed [Q_W-1:0] qx;
    logic signed [Q_W-1:0] qy;
    logic signed [Q_W:0]   cx_raw;
    logic signed [Q_W:0]   cy_raw;
    logic [IDX_W-1:0]      cx;
    logic [IDX_W-1:0]      cy;
    logic                  wr_in_grid;
    item_ctl_t             ctl;

    item_ctl_t             s1_ctl_reg;
    logic [IDX_W-1:0]      s1_row_reg;
    logic [IDX_W-1:0]      s1_col_reg;
    logic                  s1_bit_reg;
    logic signed [Q_W-1:0] s1_dx_reg;
    logic signed [Q_W-1:0] s1_dy_reg;

    assign item.ready  = advance;
    assign accept      = item.valid && advance;
    assign is_point    = (item.opcode == OP_POINT);
    assign take_origin = is_point && item.first_point;

    assign px = Q_W'(item.point_x);
    assign py = Q_W'(item.point_y);
    assign ox = take_origin ? px : Q_W'(origin_x_reg);
    assign oy = take_origin ? py : Q_W'(origin_y_reg);

    // truncate toward zero: bias negative values before the arithmetic shift
    assign qx_sum = px + (px[Q_W-1] ? Q_W'(CELL_MASK) : Q_W'(0));
    assign qy_sum = py + (py[Q_W-1] ? Q_W'(CELL_MASK) : Q_W'(0));
    assign qx     = qx_sum >>> CELL_SHIFT;
    assign qy     = qy_sum >>> CELL_SHIFT;

    assign cx_raw = (Q_W + 1)'(qx);
    assign cy_raw = qy + $signed({1'b0, y_offset});
    assign cx     = clamp_cell(cx_raw);
    assign cy     = clamp_cell(cy_raw);

    assign wr_in_grid = (32'(item.cell_x) < 32'(GRID_SIZE))
                     && (32'(item.cell_y) < 32'(GRID_SIZE));

    always_comb
    begin
        ctl          = '0;
        ctl.valid    = accept;
        ctl.is_point = is_point;
        ctl.first    = item.first_point;
        ctl.last     = item.last_point;
        ctl.map_wr   = !is_point && wr_in_grid;
    end

    assign rd_en  = accept;
    assign rd_row = is_point ? cy : IDX_W'(item.cell_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            s1_ctl_reg   <= '0;
        end
        else if (advance)
        begin
            s1_ctl_reg <= accept ? ctl : '0;
            if (accept && take_origin)
            begin
                origin_x_reg <= item.point_x;
                origin_y_reg <= item.point_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg <= rd_row;
            s1_col_reg <= is_point ? cx : IDX_W'(item.cell_x);
            s1_bit_reg <= item.cell_occupied;
            s1_dx_reg  <= px - ox;
            s1_dy_reg  <= py - oy;
        end
    end

    assign s1_ctl = s1_ctl_reg;
    assign s1_row = s1_row_reg;
    assign s1_col = s1_col_reg;
    assign s1_bit = s1_bit_reg;
    assign s1_dx  = s1_dx_reg;
    assign s1_dy  = s1_dy_reg;

endmodule

### design/tgcc_grid_mem.sv
module tgcc_grid_mem import tgcc_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         rd_en,
    input  logic [$clog2(GRID_SIZE)-1:0] rd_row,
    input  item_ctl_t                    s1_ctl,
    input  logic [$clog2(GRID_SIZE)-1:0] s1_row,
    input  logic [$clog2(GRID_SIZE)-1:0] s1_col,
    input  logic                         s1_bit,
    output logic                         hit
);

    localparam int IDX_W = $clog2(GRID_SIZE);

    logic [GRID_SIZE-1:0] mem [GRID_SIZE];

    logic [GRID_SIZE-1:0] row_valid_reg;
    logic                 rd_valid_reg;
    logic [GRID_SIZE-1:0] rd_data_reg;
    logic                 fwd_reg;
    logic [GRID_SIZE-1:0] fwd_data_reg;

    logic [GRID_SIZE-1:0] row_eff;
    logic [GRID_SIZE-1:0] row_new;
    logic                 wr_en;
    logic [IDX_W-1:0]     col_lo;
    logic [IDX_W-1:0]     col_hi;

    assign row_eff = fwd_reg      ? fwd_data_reg :
                     rd_valid_reg ? rd_data_reg  : '0;

    always_comb
    begin
        row_new         = row_eff;
        row_new[s1_col] = s1_bit;
    end

    assign wr_en = advance && s1_ctl.valid && s1_ctl.map_wr;

    assign col_lo = (s1_col == '0) ? '0 : s1_col - IDX_W'(1);
    assign col_hi = (s1_col == IDX_W'(GRID_SIZE - 1)) ? s1_col : s1_col + IDX_W'(1);
    assign hit    = row_eff[col_lo] || row_eff[s1_col] || row_eff[col_hi];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_row] <= row_new;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_row];
            fwd_data_reg <= row_new;
        end
    end

    // track which rows were ever written; bypass a row that is written at the same edge it is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[s1_row] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_row];
                fwd_reg      <= wr_en && (rd_row == s1_row);
            end
        end
    end

endmodule

### design/tgcc_verdict.sv
module tgcc_verdict import tgcc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  item_ctl_t                  s1_ctl,
    input  logic signed [COORD_BITS:0] s1_dx,
    input  logic signed [COORD_BITS:0] s1_dy,
    input  logic                       s1_hit,
    input  logic [REACH_W-1:0]         reach,
    output logic                       advance,
    tgcc_out_if.source                 result
);

    localparam int SQ_W = 2 * (COORD_BITS + 1);
    localparam int D2_W = (SQ_W + 1 > REACH_W) ? SQ_W + 1 : REACH_W;

    logic signed [SQ_W-1:0] sq_x;
    logic signed [SQ_W-1:0] sq_y;

    item_ctl_t              s2_ctl_reg;
    logic [SQ_W-1:0]        sq_x_reg;
    logic [SQ_W-1:0]        sq_y_reg;
    logic                   hit_reg;

    logic                   done_reg;
    stop_t                  stop_reg;
    logic                   done_next;
    stop_t                  stop_next;
    logic                   done_cur;
    stop_t                  stop_cur;

    logic                   out_valid_reg;
    logic                   path_clear_reg;
    stop_t                  stop_reason_reg;

    logic [D2_W-1:0]        d2;
    logic                   far;
    logic                   emit;

    assign sq_x = s1_dx * s1_dx;
    assign sq_y = s1_dy * s1_dy;

    assign advance = !out_valid_reg || result.ready;

    assign d2  = D2_W'(sq_x_reg) + D2_W'(sq_y_reg);
    assign far = d2 > D2_W'(reach);

    assign emit = s2_ctl_reg.valid && s2_ctl_reg.is_point && s2_ctl_reg.last;

    always_comb
    begin
        done_cur  = s2_ctl_reg.first ? 1'b0 : done_reg;
        stop_cur  = s2_ctl_reg.first ? STOP_NONE : stop_reg;
        done_next = done_cur;
        stop_next = stop_cur;
        priority if (done_cur)
        begin
            done_next = done_cur;
        end
        else if (far)
        begin
            done_next = 1'b1;
            stop_next = STOP_REACH;
        end
        else if (hit_reg)
        begin
            done_next = 1'b1;
            stop_next = STOP_OBSTACLE;
        end
        else
        begin
            stop_next = stop_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg    <= '0;
            done_reg      <= 1'b0;
            stop_reg      <= STOP_NONE;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_ctl_reg    <= s1_ctl;
            out_valid_reg <= emit;
            if (s2_ctl_reg.valid && s2_ctl_reg.is_point)
            begin
                if (s2_ctl_reg.last)
                begin
                    done_reg <= 1'b0;
                    stop_reg <= STOP_NONE;
                end
                else
                begin
                    done_reg <= done_next;
                    stop_reg <= stop_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_x_reg <= sq_x;
            sq_y_reg <= sq_y;
            hit_reg  <= s1_hit;
            if (emit)
            begin
                path_clear_reg  <= (stop_next != STOP_OBSTACLE);
                stop_reason_reg <= stop_next;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.path_clear  = path_clear_reg;
    assign result.stop_reason = stop_reason_reg;

endmodule

### design/trajectory_grid_collision_check_unit.sv
// The result for the last point of a trajectory passes the s1, s2 and output registers before it is valid.
// Throughput: one item per cycle; all stages hold while a result waits for its transfer.
// Each point does one grid-row read and two squares; map writes read, modify and write a row.
// Reset: row valid bits clear at once so the whole grid reads free with no clearing pass;
// origin and stop state clear, y_offset_cells returns to 15 and reach_squared to 25600.
module trajectory_grid_collision_check_unit import tgcc_pkg::*; #(
    parameter int GRID_SIZE  = GRID_SIZE_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tgcc_in_if.sink               item,
    tgcc_out_if.source            result
);

    localparam int IDX_W = $clog2(GRID_SIZE);

    logic [Y_OFFSET_W-1:0]      y_offset_reg;
    logic [REACH_W-1:0]         reach_reg;

    logic                       advance;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_row;
    item_ctl_t                  s1_ctl;
    logic [IDX_W-1:0]           s1_row;
    logic [IDX_W-1:0]           s1_col;
    logic                       s1_bit;
    logic signed [COORD_BITS:0] s1_dx;
    logic signed [COORD_BITS:0] s1_dy;
    logic                       s1_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_offset_reg <= Y_OFFSET_RESET;
            reach_reg    <= REACH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_Y_OFFSET: y_offset_reg <= cfg_data[Y_OFFSET_W-1:0];
                CFG_REACH:    reach_reg    <= cfg_data[REACH_W-1:0];
                default:      reach_reg    <= reach_reg;
            endcase
        end
    end

    tgcc_point_front #(
        .GRID_SIZE  (GRID_SIZE),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .y_offset (y_offset_reg),
        .item     (item),
        .rd_en    (rd_en),
        .rd_row   (rd_row),
        .s1_ctl   (s1_ctl),
        .s1_row   (s1_row),
        .s1_col   (s1_col),
        .s1_bit   (s1_bit),
        .s1_dx    (s1_dx),
        .s1_dy    (s1_dy)
    );

    tgcc_grid_mem #(
        .GRID_SIZE (GRID_SIZE)
    ) u_grid (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .s1_ctl  (s1_ctl),
        .s1_row  (s1_row),
        .s1_col  (s1_col),
        .s1_bit  (s1_bit),
        .hit     (s1_hit)
    );

    tgcc_verdict #(
        .COORD_BITS (COORD_BITS)
    ) u_verdict (
        .clk     (clk),
        .rst_n   (rst_n),
        .s1_ctl  (s1_ctl),
        .s1_dx   (s1_dx),
        .s1_dy   (s1_dy),
        .s1_hit  (s1_hit),
        .reach   (reach_reg),
        .advance (advance),
        .result  (result)
    );

endmodule

### test/trajectory_grid_collision_check_unit_test.sv
`timescale 1ns / 1ps

module trajectory_grid_collision_check_unit_test;
    import tgcc_pkg::*;

    localparam int CELL_UNITS   = 1 << CELL_SHIFT;
    localparam int PHASE_ITEMS  = 228;
    localparam int QUIET_CYCLES = 12;
    localparam int DRAIN_CAP    = 20000;

    typedef struct {
        opcode_t                          op;
        logic signed [COORD_BITS_DEF-1:0] px;
        logic signed [COORD_BITS_DEF-1:0] py;
        logic                             first;
        logic                             last;
        logic [CELL_W-1:0]                cx;
        logic [CELL_W-1:0]                cy;
        logic                             occ;
    } grid_item_t;

    typedef struct {
        logic  path_clear;
        stop_t reason;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tgcc_in_if  item_ch ();
    tgcc_out_if result_ch ();

    trajectory_grid_collision_check_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    logic                  grid [GRID_SIZE_DEF][GRID_SIZE_DEF];
    int                    org_x;
    int                    org_y;
    logic                  trace_done;
    stop_t                 trace_stop;
    logic [Y_OFFSET_W-1:0] y_off;
    logic [REACH_W-1:0]    reach;

    grid_item_t pending_items[$];
    grid_item_t cur_item;
    verdict_t   verdicts[$];
    verdict_t   want;

    int   errors;
    int   sent_items;
    int   checked_results;
    int   blocked_results;
    int   reach_results;
    int   settings_run;
    int   queued;
    int   send_gap;
    int   stall_left;
    logic took;
    logic hold_send;
    logic steady;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int clamp_cell(input int c);
        if (c < 0)
            return 0;
        if (c > GRID_SIZE_DEF - 1)
            return GRID_SIZE_DEF - 1;
        return c;
    endfunction

    function automatic logic cell_hit(input int cx, input int cy);
        return grid[clamp_cell(cx)][clamp_cell(cy)];
    endfunction

    function automatic void apply_item(input grid_item_t it);
        int       px;
        int       py;
        int       cx;
        int       cy;
        longint   dx;
        longint   dy;
        longint   d2;
        verdict_t v;
        if (it.op == OP_MAP_WRITE)
        begin
            grid[it.cx][it.cy] = it.occ;
            return;
        end
        px = it.px;
        py = it.py;
        if (it.first)
        begin
            org_x      = px;
            org_y      = py;
            trace_done = 1'b0;
            trace_stop = STOP_NONE;
        end
        if (!trace_done)
        begin
            dx = px - org_x;
            dy = py - org_y;
            d2 = dx * dx + dy * dy;
            if (d2 > longint'({32'd0, reach}))
            begin
                trace_done = 1'b1;
                trace_stop = STOP_REACH;
            end
            else
            begin
                cx = clamp_cell(px / CELL_UNITS);
                cy = clamp_cell(py / CELL_UNITS + int'(y_off));
                if (cell_hit(cx, cy) || cell_hit(cx + 1, cy) || cell_hit(cx - 1, cy))
                begin
                    trace_done = 1'b1;
                    trace_stop = STOP_OBSTACLE;
                end
            end
        end
        if (it.last)
        begin
            v.path_clear = (trace_stop != STOP_OBSTACLE);
            v.reason     = trace_stop;
            verdicts.insert(verdicts.size(), v);
            trace_done = 1'b0;
            trace_stop = STOP_NONE;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic push_item(input grid_item_t it);
        pending_items.insert(pending_items.size(), it);
        queued++;
    endtask

    task automatic add_point(input int x, input int y, input logic f, input logic l);
        grid_item_t it;
        it.op    = OP_POINT;
        it.px    = x[15:0];
        it.py    = y[15:0];
        it.first = f;
        it.last  = l;
        it.cx    = CELL_W'($urandom);
        it.cy    = CELL_W'($urandom);
        it.occ   = 1'($urandom);
        push_item(it);
    endtask

    task automatic add_map(input int x, input int y, input logic occ);
        grid_item_t it;
        it.op    = OP_MAP_WRITE;
        it.px    = COORD_BITS_DEF'($urandom);
        it.py    = COORD_BITS_DEF'($urandom);
        it.first = 1'($urandom);
        it.last  = 1'($urandom);
        it.cx    = x[CELL_W-1:0];
        it.cy    = y[CELL_W-1:0];
        it.occ   = occ;
        push_item(it);
    endtask

    task automatic add_random_map();
        add_map($urandom_range(31), $urandom_range(31), $urandom_range(99) < 9);
    endtask

    task automatic add_noise();
        grid_item_t it;
        it.op    = opcode_t'($urandom_range(1));
        it.px    = COORD_BITS_DEF'($urandom);
        it.py    = COORD_BITS_DEF'($urandom);
        it.first = 1'($urandom);
        it.last  = 1'($urandom);
        it.cx    = CELL_W'($urandom);
        it.cy    = CELL_W'($urandom);
        it.occ   = 1'($urandom);
        push_item(it);
    endtask

    task automatic add_trajectory();
        int   n;
        int   x;
        int   y;
        int   k;
        logic with_first;
        logic with_last;
        n          = $urandom_range(1, 12);
        x          = $urandom_range(0, 560) - 24;
        y          = $urandom_range(0, 600) - 300;
        with_first = ($urandom_range(99) < 88);
        with_last  = ($urandom_range(99) < 95);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 8)
                add_random_map();
            add_point(x, y, with_first && k == 0, with_last && k == n - 1);
            x += $urandom_range(0, 100) - 40;
            y += $urandom_range(0, 60) - 30;
        end
    endtask

    task automatic fill_phase(input int target);
        int stop_at;
        int r;
        int k;
        stop_at = queued + target;
        while (queued < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 70)
                add_trajectory();
            else if (r < 85)
                for (k = $urandom_range(1, 6); k > 0; k--)
                    add_random_map();
            else
                add_noise();
        end
    endtask

    task automatic wait_quiet(input int need, input int cap);
        int calm;
        int spent;
        calm  = 0;
        spent = 0;
        while (calm < need && spent < cap)
        begin
            @(negedge clk);
            spent++;
            if (!item_ch.valid && verdicts.size() == 0)
                calm++;
            else
                calm = 0;
        end
        if (calm < need)
            flag_mismatch($sformatf("%0d expected results never arrived", verdicts.size()));
    endtask

    task automatic settle();
        while (pending_items.size() != 0)
            @(negedge clk);
        wait_quiet(QUIET_CYCLES, DRAIN_CAP);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        if (idx == CFG_Y_OFFSET)
            y_off = data[Y_OFFSET_W-1:0];
        else
            reach = data[REACH_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || took)
        begin
            took = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                item_ch.valid <= 1'b0;
            end
            else if (hold_send || pending_items.size() == 0)
                item_ch.valid <= 1'b0;
            else
            begin
                cur_item = pending_items.pop_front();
                item_ch.opcode        <= cur_item.op;
                item_ch.point_x       <= cur_item.px;
                item_ch.point_y       <= cur_item.py;
                item_ch.first_point   <= cur_item.first;
                item_ch.last_point    <= cur_item.last;
                item_ch.cell_x        <= cur_item.cx;
                item_ch.cell_y        <= cur_item.cy;
                item_ch.cell_occupied <= cur_item.occ;
                item_ch.valid         <= 1'b1;
                send_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            apply_item(cur_item);
            took = 1'b1;
            sent_items++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            checked_results++;
            if (result_ch.stop_reason == STOP_OBSTACLE)
                blocked_results++;
            if (result_ch.stop_reason == STOP_REACH)
                reach_results++;
            if (verdicts.size() == 0)
                flag_mismatch("result transfer with nothing expected");
            else
            begin
                want = verdicts.pop_front();
                if (result_ch.path_clear !== want.path_clear)
                    flag_mismatch($sformatf("path_clear %b, expected %b",
                                            result_ch.path_clear, want.path_clear));
                if (result_ch.stop_reason !== want.reason)
                    flag_mismatch($sformatf("stop_reason %0d, expected %0d",
                                            result_ch.stop_reason, want.reason));
            end
        end
    end

    initial
    begin
        int                    p;
        int                    x;
        int                    y;
        logic [Y_OFFSET_W-1:0] yo;
        logic [REACH_W-1:0]    rs;
        item_ch.valid         = 1'b0;
        item_ch.opcode        = OP_MAP_WRITE;
        item_ch.point_x       = '0;
        item_ch.point_y       = '0;
        item_ch.first_point   = 1'b0;
        item_ch.last_point    = 1'b0;
        item_ch.cell_x        = '0;
        item_ch.cell_y        = '0;
        item_ch.cell_occupied = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_Y_OFFSET;
        cfg_data              = '0;
        rst_n                 = 1'b0;
        took                  = 1'b0;
        hold_send             = 1'b0;
        steady                = 1'b0;
        send_gap              = 0;
        stall_left            = 0;
        errors                = 0;
        sent_items            = 0;
        checked_results       = 0;
        blocked_results       = 0;
        reach_results         = 0;
        settings_run          = 1;
        queued                = 0;
        for (x = 0; x < GRID_SIZE_DEF; x++)
            for (y = 0; y < GRID_SIZE_DEF; y++)
                grid[x][y] = 1'b0;
        org_x      = 0;
        org_y      = 0;
        trace_done = 1'b0;
        trace_stop = STOP_NONE;
        y_off      = Y_OFFSET_RESET;
        reach      = REACH_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // obstacle under the point itself
        add_map(0, 15, 1'b1);
        add_point(0, 0, 1'b1, 1'b1);
        // extreme corners, far outside reach; then a point with no new origin
        add_point(-32768, -32768, 1'b1, 1'b0);
        add_point(32767, 32767, 1'b0, 1'b1);
        add_point(16, 0, 1'b0, 1'b1);
        // clamp at the high edge, neighbour column clamped too
        add_map(31, 31, 1'b1);
        add_point(32767, 32767, 1'b1, 1'b1);
        // truncation toward zero on negative coordinates
        add_map(0, 14, 1'b1);
        add_point(-15, -17, 1'b1, 1'b1);
        add_map(0, 14, 1'b0);
        add_map(0, 15, 1'b0);
        // leave reach, then points after checking has stopped
        add_point(100, 0, 1'b1, 1'b0);
        add_point(116, 0, 1'b0, 1'b0);
        add_point(400, 0, 1'b0, 1'b0);
        add_point(16, 0, 1'b0, 1'b0);
        add_point(-32768, 32767, 1'b0, 1'b1);
        // left and right neighbour columns
        add_map(5, 20, 1'b1);
        add_point(64, 80, 1'b1, 1'b1);
        add_point(96, 80, 1'b1, 1'b1);
        add_noise();
        add_point(200, 0, 1'b1, 1'b1);
        add_point(-32768, -32768, 1'b1, 1'b1);
        add_map(5, 20, 1'b0);
        add_point(80, 80, 1'b1, 1'b1);
        fill_phase(PHASE_ITEMS - 20);
        settle();

        for (p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    yo = Y_OFFSET_W'(0);
                    rs = 0;
                end
                1:
                begin
                    yo = Y_OFFSET_W'(31);
                    rs = 32'hFFFF_FFFF;
                end
                2:
                begin
                    yo = Y_OFFSET_RESET;
                    rs = REACH_RESET;
                end
                3:
                begin
                    yo = Y_OFFSET_W'($urandom);
                    rs = $urandom_range(1000, 200000);
                end
                4:
                begin
                    yo = Y_OFFSET_W'(7);
                    rs = 6400;
                end
                5:
                begin
                    yo = Y_OFFSET_W'($urandom);
                    rs = $urandom;
                end
                default:
                begin
                    yo = Y_OFFSET_W'(20);
                    rs = 90000;
                end
            endcase
            write_reg(CFG_Y_OFFSET, CFG_DATA_W'(yo));
            write_reg(CFG_REACH, rs);
            settings_run++;
            steady = (p == 2);
            fill_phase(PHASE_ITEMS);
            if (p == 4)
            begin
                while (pending_items.size() > PHASE_ITEMS / 2)
                    @(negedge clk);
                hold_send = 1'b1;
                wait_quiet(QUIET_CYCLES, DRAIN_CAP);
                hold_send = 1'b0;
            end
            settle();
        end

        $display("Sent %0d items (map writes, trajectories, noise) under %0d register settings",
                 sent_items, settings_run);
        $display("Checked %0d path results: %0d blocked, %0d stopped at reach limit",
                 checked_results, blocked_results, reach_results);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
